### hdl/gtb_pkg.sv
package gtb_pkg;

    // Table geometry: STEPS + 1 entries, indexed by a 7-bit stop or entry index.
    localparam int STEPS     = 100;
    localparam int TBL_DEPTH = STEPS + 1;
    localparam int IDX_W     = 7;

    // Colour channels: red, green, blue, alpha, eight bits each.
    localparam int CH_W   = 8;
    localparam int CH_NUM = 4;

    // Slope division: one quotient bit per cycle over a channel-wide dividend.
    localparam int DIV_STEPS = CH_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Signed slope quotient and signed running quotient of the fill.
    localparam int DQ_W = CH_W + 1;
    localparam int Q_W  = CH_W + 2;

    // One table word; element 0 is red in bits 7..0, element 3 is alpha.
    typedef logic [CH_NUM-1:0][CH_W-1:0] t_rgba;

    typedef logic signed [DQ_W-1:0] t_dq;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SLOPE,
        ST_FILL,
        ST_READ
    } t_state;

    // Write request to the gradient table.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_rgba            data;
    } t_tbl_wr;

endpackage

### hdl/gtb_if.sv
interface gtb_in_if import gtb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [1:0]       opcode;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
    logic [CH_W-1:0]  alpha_in;

    modport source (
        output valid, opcode, entry_index, red_in, green_in, blue_in, alpha_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, red_in, green_in, blue_in, alpha_in,
        output ready
    );
endinterface

interface gtb_out_if import gtb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] alpha_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out,
        output ready
    );
endinterface

### hdl/gradient_table_builder_unit.sv
// Gradient table builder: holds a 101-entry RGBA table in an on-chip memory
// and builds it from colour stops given in ascending index order. A start
// transfer clears the table and writes the first stop; an add transfer writes
// its stop and, when its index lies more than one above the previous stop,
// fills the entries in between by exact linear interpolation, floor rounding
// per channel. The fill consists of one memory read of the previous stop, a
// shared slope division for all four channels, then one table write per
// cycle. A read transfer reads the table memory and returns the entry
// through an output register, so the next transfer is taken while a result
// waits; an index above 100 reads as all zero, and start or add at such an
// index is ignored. Opcode 3 is ignored. Only one transfer is in work at a
// time.
module gradient_table_builder_unit import gtb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    gtb_in_if.sink    i_in,
    gtb_out_if.source o_out
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_span, n_span;
    t_rgba            r_e, n_e;
    t_rgba            r_s, n_s;
    logic [Q_W-1:0]   r_q [CH_NUM];
    logic [Q_W-1:0]   n_q [CH_NUM];
    logic [IDX_W-1:0] r_r [CH_NUM];
    logic [IDX_W-1:0] n_r [CH_NUM];
    logic             r_rd_zero, n_rd_zero;
    logic             r_out_valid, n_out_valid;
    t_rgba            r_out_data, n_out_data;

    t_op              in_op;
    logic [IDX_W-1:0] in_idx;
    logic             in_range;
    t_rgba            in_rgba;

    t_tbl_wr          tbl_wr;
    logic             tbl_clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_rgba            rd_data;

    logic             slope_go;
    logic             slope_done;
    t_dq              dq [CH_NUM];
    logic [IDX_W-1:0] dr [CH_NUM];

    logic [IDX_W:0]   sum_r  [CH_NUM];
    logic             carry  [CH_NUM];
    logic [IDX_W:0]   fix_r  [CH_NUM];
    logic [Q_W-1:0]   fill_q [CH_NUM];
    logic [IDX_W-1:0] fill_r [CH_NUM];
    logic [Q_W-1:0]   val    [CH_NUM];
    t_rgba            fill_rgba;

    assign in_op    = t_op'(i_in.opcode);
    assign in_idx   = i_in.entry_index;
    assign in_range = in_idx <= IDX_W'(STEPS);
    assign in_rgba  = {i_in.alpha_in, i_in.blue_in, i_in.green_in, i_in.red_in};

    gtb_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_clear   (tbl_clear),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gtb_slope u_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (slope_go),
        .i_start (rd_data),
        .i_end   (r_e),
        .i_span  (r_span),
        .o_done  (slope_done),
        .o_dq    (dq),
        .o_dr    (dr)
    );

    // Each fill step advances k*delta = q*span + r by one slope: the
    // remainder gains the slope remainder and carries into the quotient
    // when it reaches the span, so the value is always start + floor().
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            sum_r[c]  = {1'b0, r_r[c]} + {1'b0, dr[c]};
            carry[c]  = sum_r[c] >= {1'b0, r_span};
            fix_r[c]  = carry[c] ? (sum_r[c] - {1'b0, r_span}) : sum_r[c];
            fill_r[c] = fix_r[c][IDX_W-1:0];
            fill_q[c] = r_q[c] + {{(Q_W-DQ_W){dq[c][DQ_W-1]}}, dq[c]}
                      + Q_W'(carry[c]);
            val[c]    = Q_W'(r_s[c]) + fill_q[c];
            fill_rgba[c] = val[c][CH_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_j         = r_j;
        n_i         = r_i;
        n_span      = r_span;
        n_e         = r_e;
        n_s         = r_s;
        n_q         = r_q;
        n_r         = r_r;
        n_rd_zero   = r_rd_zero;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        i_in.ready  = 1'b0;
        tbl_wr      = '0;
        tbl_clear   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_prev;
        slope_go    = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    unique case (in_op)
                        OP_START: begin
                            if (in_range) begin
                                tbl_clear = 1'b1;
                                tbl_wr    = '{en: 1'b1, addr: in_idx, data: in_rgba};
                                n_prev    = in_idx;
                            end
                        end
                        OP_ADD: begin
                            if (in_range) begin
                                // The new stop goes in now; the previous stop
                                // is read in the same cycle for the fill.
                                tbl_wr  = '{en: 1'b1, addr: in_idx, data: in_rgba};
                                rd_en   = 1'b1;
                                rd_addr = r_prev;
                                n_prev  = in_idx;
                                n_i     = in_idx;
                                n_j     = r_prev + 1'b1;
                                n_span  = in_idx - r_prev;
                                n_e     = in_rgba;
                                if ({1'b0, in_idx} > ({1'b0, r_prev} + 1'b1)) begin
                                    n_state = ST_LOAD;
                                end
                            end
                        end
                        OP_READ: begin
                            rd_en     = in_range;
                            rd_addr   = in_idx;
                            n_rd_zero = !in_range;
                            n_state   = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                // The previous stop colour is on the read port now.
                n_s      = rd_data;
                slope_go = 1'b1;
                n_q      = '{default: '0};
                n_r      = '{default: '0};
                n_state  = ST_SLOPE;
            end
            ST_SLOPE: begin
                if (slope_done) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                tbl_wr = '{en: 1'b1, addr: r_j, data: fill_rgba};
                n_q    = fill_q;
                n_r    = fill_r;
                n_j    = r_j + 1'b1;
                if (IDX_W'(r_j + 1'b1) == r_i) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_zero ? '0 : rd_data;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j        <= n_j;
        r_i        <= n_i;
        r_span     <= n_span;
        r_e        <= n_e;
        r_s        <= n_s;
        r_q        <= n_q;
        r_r        <= n_r;
        r_rd_zero  <= n_rd_zero;
        r_out_data <= n_out_data;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.red_out   = r_out_data[0];
    assign o_out.green_out = r_out_data[1];
    assign o_out.blue_out  = r_out_data[2];
    assign o_out.alpha_out = r_out_data[3];

endmodule

### hdl/gtb_table.sv
module gtb_table import gtb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tbl_wr          i_wr,
    input  logic             i_clear,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_rgba            o_rd_data
);

    t_rgba                r_mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] r_valid;
    logic [TBL_DEPTH-1:0] n_valid;
    t_rgba                r_rd_data;
    logic                 r_rd_ok;

    // An entry never written since reset or the last clear reads as zero.
    always_comb begin
        n_valid = i_clear ? '0 : r_valid;
        if (i_wr.en) begin
            n_valid[i_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

### hdl/gtb_slope.sv
module gtb_slope import gtb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  t_rgba            i_start,
    input  t_rgba            i_end,
    input  logic [IDX_W-1:0] i_span,
    output logic             o_done,
    output t_dq              o_dq [CH_NUM],
    output logic [IDX_W-1:0] o_dr [CH_NUM]
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_span;
    logic             r_neg [CH_NUM];
    logic [CH_W-1:0]  r_dvd [CH_NUM];
    logic [IDX_W-1:0] r_rem [CH_NUM];
    t_dq              r_dq  [CH_NUM];
    logic [IDX_W-1:0] r_dr  [CH_NUM];

    logic [CH_W:0]    diff  [CH_NUM];
    logic [CH_W:0]    shl   [CH_NUM];
    logic             ge    [CH_NUM];
    logic [CH_W:0]    sub   [CH_NUM];
    t_dq              qpos  [CH_NUM];

    // Restoring division of |end - start| by the span, one bit per cycle.
    always_comb begin
        for (int c = 0; c < CH_NUM; c++) begin
            diff[c] = {1'b0, i_end[c]} - {1'b0, i_start[c]};
            shl[c]  = {1'b0, r_rem[c], r_dvd[c][CH_W-1]};
            ge[c]   = shl[c] >= {2'b00, r_span};
            sub[c]  = shl[c] - {2'b00, r_span};
            qpos[c] = t_dq'({1'b0, r_dvd[c]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_span <= i_span;
            for (int c = 0; c < CH_NUM; c++) begin
                r_neg[c] <= diff[c][CH_W];
                r_dvd[c] <= diff[c][CH_W] ? CH_W'(-diff[c]) : diff[c][CH_W-1:0];
                r_rem[c] <= '0;
            end
        end else if (r_busy) begin
            for (int c = 0; c < CH_NUM; c++) begin
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    // Turn the magnitude result into a floor quotient with a
                    // non-negative remainder.
                    if (r_neg[c] && (r_rem[c] != '0)) begin
                        r_dq[c] <= -qpos[c] - t_dq'(1);
                        r_dr[c] <= r_span - r_rem[c];
                    end else if (r_neg[c]) begin
                        r_dq[c] <= -qpos[c];
                        r_dr[c] <= '0;
                    end else begin
                        r_dq[c] <= qpos[c];
                        r_dr[c] <= r_rem[c];
                    end
                end else begin
                    r_dvd[c] <= {r_dvd[c][CH_W-2:0], ge[c]};
                    r_rem[c] <= ge[c] ? sub[c][IDX_W-1:0] : shl[c][IDX_W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_dq   = r_dq;
    assign o_dr   = r_dr;

endmodule
